// ----- rtl/core/mbe_pkg.sv -----
// Shared constants and types for the Mandelbrot escape-time iterator.
// No dependencies; used by the interfaces and all core modules.
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRACTION_BITS = 28;
  localparam int LIMIT_WIDTH   = 11;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(256);

  // While a point is still inside, |z| < 2, so one guard bit above the
  // coordinate width holds z after the next update.
  localparam int Z_WIDTH    = COORD_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * Z_WIDTH - FRACTION_BITS + 1;
  localparam int MAG_WIDTH  = PROD_WIDTH + 1;

  localparam logic [MAG_WIDTH-1:0] ESCAPE_BOUND = MAG_WIDTH'(4) << FRACTION_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                          quick;
    logic signed [COORD_WIDTH-1:0] c_real;
    logic signed [COORD_WIDTH-1:0] c_imag;
  } mbe_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/mbe_if.sv -----
// Valid/ready channel interfaces for points in and iteration counts out.
// Depends on mbe_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mbe_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mbe_pkg::COORD_WIDTH-1:0] c_real;
  logic signed [mbe_pkg::COORD_WIDTH-1:0] c_imag;

  modport source(output valid, c_real, c_imag, input ready);
  modport sink(input valid, c_real, c_imag, output ready);
endinterface

interface mbe_out_if;
  logic                            valid;
  logic                            ready;
  logic [mbe_pkg::LIMIT_WIDTH-1:0] iterations;

  modport source(output valid, iterations, input ready);
  modport sink(input valid, iterations, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mbe_front.sv -----
// Input stage: registers each point and flags points that escape on the
// first iteration. Depends on mbe_pkg and mbe_in_if.
`timescale 1ns / 1ps
`default_nettype none

module mbe_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  mbe_in_if.sink                  in_ch,
  output logic                    item_valid,
  output mbe_pkg::mbe_item_t      item,
  input  wire logic               item_ready
);

  logic               valid_r, valid_nxt;
  mbe_pkg::mbe_item_t item_r, item_nxt;
  logic               take;

  // |c| >= 2 in either part means |c|^2 >= 4 after the first update
  function automatic logic far_out(input logic signed [mbe_pkg::COORD_WIDTH-1:0] v);
    logic [mbe_pkg::COORD_WIDTH-mbe_pkg::FRACTION_BITS-2:0] top;
    top = v[mbe_pkg::COORD_WIDTH-1:mbe_pkg::FRACTION_BITS+1];
    return !((&top) || !(|top));
  endfunction

  assign in_ch.ready = !valid_r || item_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (item_ready) begin
      valid_nxt = 1'b0;
    end
    if (take) begin
      valid_nxt       = 1'b1;
      item_nxt.c_real = in_ch.c_real;
      item_nxt.c_imag = in_ch.c_imag;
      item_nxt.quick  = far_out(in_ch.c_real) || far_out(in_ch.c_imag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ----- rtl/core/mbe_queue.sv -----
// Short FIFO between the input stage and the iteration engine.
// Depends on mbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbe_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  input  wire mbe_pkg::mbe_item_t push_item,
  output logic                    push_ready,
  output logic                    pop_valid,
  output mbe_pkg::mbe_item_t      pop_item,
  input  wire logic               pop
);

  mbe_pkg::mbe_item_t                entries_r [mbe_pkg::QUEUE_DEPTH];
  logic [mbe_pkg::QPTR_WIDTH-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mbe_pkg::QPTR_WIDTH-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mbe_pkg::QCNT_WIDTH-1:0]    count_r, count_nxt;
  logic                              do_push, do_pop;

  assign push_ready = count_r != mbe_pkg::QCNT_WIDTH'(mbe_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [mbe_pkg::QPTR_WIDTH-1:0] ptr_inc(
      input logic [mbe_pkg::QPTR_WIDTH-1:0] p);
    if (p == mbe_pkg::QPTR_WIDTH'(mbe_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mbe_engine.sv -----
// Iteration engine: z = z*z + c with a shared set of three multipliers,
// escape test, and the result register. Depends on mbe_pkg and mbe_out_if.
`timescale 1ns / 1ps
`default_nettype none

module mbe_engine (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [mbe_pkg::LIMIT_WIDTH-1:0] limit,
  input  wire logic                            q_valid,
  input  wire mbe_pkg::mbe_item_t              q_item,
  output logic                                 q_pop,
  mbe_out_if.source                            out_ch
);

  localparam int ZW = mbe_pkg::Z_WIDTH;
  localparam int PW = mbe_pkg::PROD_WIDTH;
  localparam int MW = mbe_pkg::MAG_WIDTH;
  localparam int CW = mbe_pkg::COORD_WIDTH;
  localparam int LW = mbe_pkg::LIMIT_WIDTH;
  localparam int FB = mbe_pkg::FRACTION_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [LW-1:0]        out_iter_r, out_iter_nxt;
  logic [LW-1:0]        count_r, count_nxt;
  logic signed [ZW-1:0] zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [CW-1:0] cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [PW-1:0] rr_r, rr_nxt, ii_r, ii_nxt, xr_r, xr_nxt;

  logic signed [2*ZW-1:0] sq_r_full, sq_i_full, cross_full;
  logic [MW-1:0]          mag;
  logic                   bounded, done, slot_free;

  assign sq_r_full  = zr_r * zr_r;
  assign sq_i_full  = zi_r * zi_r;
  assign cross_full = zr_r * zi_r;

  assign mag       = MW'(rr_r) + MW'(ii_r);
  assign bounded   = mag[MW-1] || (mag < mbe_pkg::ESCAPE_BOUND);
  assign done      = !bounded || (count_r >= limit);
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_iter_nxt  = out_iter_r;
    count_nxt     = count_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    rr_nxt        = rr_r;
    ii_nxt        = ii_r;
    xr_nxt        = xr_r;
    q_pop         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          // first update from z = 0 gives z = c
          q_pop     = 1'b1;
          zr_nxt    = ZW'(q_item.c_real);
          zi_nxt    = ZW'(q_item.c_imag);
          cr_nxt    = q_item.c_real;
          ci_nxt    = q_item.c_imag;
          count_nxt = LW'(1);
          state_nxt = q_item.quick ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        rr_nxt    = PW'(sq_r_full >>> FB);
        ii_nxt    = PW'(sq_i_full >>> FB);
        xr_nxt    = PW'(cross_full >>> (FB - 1));
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (done) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_iter_nxt  = count_r;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          zr_nxt    = ZW'(rr_r - ii_r + PW'(cr_r));
          zi_nxt    = ZW'(xr_r + PW'(ci_r));
          count_nxt = count_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_iter_nxt  = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_iter_r <= out_iter_nxt;
    count_r    <= count_nxt;
    zr_r       <= zr_nxt;
    zi_r       <= zi_nxt;
    cr_r       <= cr_nxt;
    ci_r       <= ci_nxt;
    rr_r       <= rr_nxt;
    ii_r       <= ii_nxt;
    xr_r       <= xr_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.iterations = out_iter_r;

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE)
    else $error("queue popped while busy");

  a_mul_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |=> state_r == ST_UPD)
    else $error("products not followed by update");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> count_r != '0)
    else $error("iteration count zero while busy");

  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_iter_r != '0)
    else $error("result with zero iterations");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_iter_r))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- rtl/core/mandelbrot_escape_iterator.sv -----
// Mandelbrot escape-time iterator, top level.
// Depends on mbe_pkg, mbe_if, mbe_front, mbe_queue and mbe_engine.
//
// Usage:
//   in_ch carries one point c (c_real, c_imag, signed, 28 fraction bits);
//   out_ch returns one transaction per point: the iteration count, from 1
//   up to iteration_limit (a limit of 0 acts as 1). Results come in input
//   order. cfg_wr_en/cfg_wr_data write iteration_limit; write it only
//   while no point is in flight.
//   Points are registered at the input, flagged there when they escape on
//   the first iteration, and held in a two-entry queue ahead of the engine.
//   The engine loads a point, then runs each iteration as a multiply step
//   (three multipliers) followed by the update and escape test; flagged
//   points go from loading straight to the result. A point passes the input
//   register, the queue, the engine and the result register on its way out.
//   The engine takes the next point only once the current one is finished.
//   Reset (synchronous, rst_n low) empties the queue and the result
//   register and sets iteration_limit to 256.
//   A stalled receiver holds the result; the engine waits, while the input
//   stage and queue keep taking up to three further points.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_iterator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [mbe_pkg::LIMIT_WIDTH-1:0] cfg_wr_data,
  mbe_in_if.sink                               in_ch,
  mbe_out_if.source                            out_ch
);

  logic [mbe_pkg::LIMIT_WIDTH-1:0] limit_r, limit_nxt;

  logic               front_valid, front_ready;
  mbe_pkg::mbe_item_t front_item;
  logic               q_valid, q_pop;
  mbe_pkg::mbe_item_t q_item;

  assign limit_nxt = cfg_wr_en ? cfg_wr_data : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mbe_pkg::LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  mbe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (front_valid),
    .item       (front_item),
    .item_ready (front_ready)
  );

  mbe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_item  (front_item),
    .push_ready (front_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  mbe_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .limit   (limit_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
